// File: src/rpn_stack_evaluator_assert.svh
// assertion macros for the postfix evaluator
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
`define RPN_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/rpn_pkg.sv
// types and constants of the postfix evaluator
package rpn_pkg;
    localparam logic OP_KIND_NUM = 1'b0;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIN, S_DONE
    } state_t;

    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        begin
            if (v > 64'sh000000007fffffff) r = SAT_MAX;
            else if (v < -64'sh0000000080000000) r = SAT_MIN;
            else r = v[31:0];
            return r;
        end
    endfunction
endpackage

// File: src/rpn_stack_evaluator.sv
// postfix expression evaluator top level
//
// channel   | signals                               | handshake
// token in  | req_type, number_value, op_code       | start && !busy
// result    | top_value, stack_depth, status        | done strobe, one cycle
//
// states from the accepting edge to the done strobe:
// push, full and underflow: done; add, sub, unknown: read, exec, fin, done; divide by zero: read, exec, done
// multiply: read, exec, mul, fin, done (four 16x16 partial products in mul, one per cycle)
// divide: read, exec, div, fin, done, one quotient bit per cycle over 48 bits
// busy stays high through the strobe, a new token is accepted only from idle, after the strobe
// the top of stack is kept in a register, the rest lives in the ram
// reset empties the stack; ram contents are not cleared
// the result strobe cannot be stalled
`include "rpn_stack_evaluator_assert.svh"

module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic signed [31:0] number_value,
    input  logic [2:0]         op_code,
    output logic               done,
    output logic signed [31:0] top_value,
    output logic [6:0]         stack_depth,
    output logic [1:0]         status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [31:0] top_reg, top_next;
    logic kind_reg, kind_next;
    logic [2:0] op_reg, op_next;
    logic [1:0] st_reg, st_next;
    logic signed [31:0] left_reg, left_next;
    logic signed [31:0] right_reg, right_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [1:0] mstep_reg, mstep_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [5:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic [31:0] dvs_reg, dvs_next;

    logic we;
    logic [AW-1:0] addr;
    logic [31:0] wdata, rdata;

    rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [31:0] lmag, rmag;
    logic [15:0] ma, mb;
    logic [31:0] pp;
    logic signed [63:0] sum;
    logic [48:0] trial;
    logic [63:0] qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next; kind_reg <= kind_next; op_reg <= op_next;
        st_reg <= st_next; left_reg <= left_next; right_reg <= right_next;
        acc_reg <= acc_next; mstep_reg <= mstep_next; rem_reg <= rem_next;
        quo_reg <= quo_next; dvd_reg <= dvd_next; cnt_reg <= cnt_next;
        neg_reg <= neg_next; dvs_reg <= dvs_next;
    end

    always_comb
    begin
        state_next = state_reg; sp_next = sp_reg; top_next = top_reg;
        kind_next = kind_reg; op_next = op_reg; st_next = st_reg;
        left_next = left_reg; right_next = right_reg; acc_next = acc_reg;
        mstep_next = mstep_reg; rem_next = rem_reg; quo_next = quo_reg;
        dvd_next = dvd_reg; cnt_next = cnt_reg; neg_next = neg_reg;
        dvs_next = dvs_reg;
        we = 1'b0; addr = '0; wdata = top_reg;
        busy = (state_reg != S_IDLE);
        done = 1'b0;
        lmag = left_reg[31] ? 32'(-left_reg) : left_reg;
        rmag = right_reg[31] ? 32'(-right_reg) : right_reg;
        ma = mstep_reg[0] ? lmag[31:16] : lmag[15:0];
        mb = mstep_reg[1] ? rmag[31:16] : rmag[15:0];
        pp = ma * mb;
        sum = acc_reg + ($signed({32'd0, pp})
            <<< (16 * (32'(mstep_reg[0]) + 32'(mstep_reg[1]))));
        trial = {rem_reg, dvd_reg[47]} - {17'd0, dvs_reg};
        qs = {16'd0, quo_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = req_type; op_next = op_code;
                    left_next = number_value; st_next = ST_OK;
                    if (req_type == OP_KIND_NUM)
                    begin
                        if (sp_reg >= PW'(STACK_DEPTH))
                        begin
                            sp_next = '0; st_next = ST_FULL; state_next = S_DONE;
                        end
                        else
                        begin
                            // spill old top into ram below the new one
                            if (sp_reg != '0)
                            begin
                                we = 1'b1; addr = AW'(sp_reg - 1'b1); wdata = top_reg;
                            end
                            top_next = number_value; sp_next = sp_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    else if (sp_reg < PW'(2))
                    begin
                        sp_next = '0; st_next = ST_UNDER; state_next = S_DONE;
                    end
                    else
                    begin
                        addr = AW'(sp_reg - PW'(2));
                        right_next = top_reg;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                addr = AW'(sp_reg - PW'(2));
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                left_next = rdata;
                acc_next = '0; mstep_next = '0;
                case (op_reg)
                    OP_ADD:
                    begin
                        top_next = sat64(64'(signed'(rdata)) + 64'(right_reg));
                        state_next = S_FIN;
                    end
                    OP_SUB:
                    begin
                        top_next = sat64(64'(signed'(rdata)) - 64'(right_reg));
                        state_next = S_FIN;
                    end
                    OP_MUL: state_next = S_MUL;
                    OP_DIV:
                    begin
                        if (right_reg == 0)
                        begin
                            sp_next = '0; st_next = ST_DIVZ; state_next = S_DONE;
                        end
                        else
                        begin
                            dvd_next = {(rdata[31] ? 32'(-signed'(rdata)) : rdata), 16'd0};
                            dvs_next = rmag; rem_next = '0; quo_next = '0;
                            cnt_next = 6'd47; state_next = S_DIV;
                            neg_next = rdata[31] ^ right_reg[31];
                        end
                    end
                    default: begin top_next = '0; state_next = S_FIN; end
                endcase
            end
            S_MUL:
            begin
                acc_next = sum; mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 2'd3)
                begin
                    neg_next = left_reg[31] ^ right_reg[31];
                    top_next = sat64((left_reg[31] ^ right_reg[31])
                        ? -(sum >>> 16) : (sum >>> 16));
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                dvd_next = {dvd_reg[46:0], 1'b0};
                if (!trial[48])
                begin
                    rem_next = trial[47:0]; quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[46:0], dvd_reg[47]};
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FIN;
                if (state_next == S_FIN)
                    top_next = '0;
            end
            S_FIN:
            begin
                if (op_reg == OP_DIV)
                    top_next = sat64(neg_reg ? -signed'(qs) : signed'(qs));
                sp_next = sp_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign top_value = (sp_reg == '0) ? 32'sd0 : signed'(top_reg);
    assign stack_depth = 7'(sp_reg);
    assign status = st_reg;

    `RPN_ASSERT_IMPL(a_done_idle, clk, rst_n, done, busy, "done outside busy")
    `RPN_ASSERT_NEXT(a_done_once, clk, rst_n, done, !done, "double strobe")
    `RPN_ASSERT_IMPL(a_err_empty, clk, rst_n, done && status != ST_OK, stack_depth == '0, "kept")
    `RPN_ASSERT_IMPL(a_sp_range, clk, rst_n, 1'b1, sp_reg <= PW'(STACK_DEPTH), "pointer range")
endmodule

// File: src/rpn_ram.sv
// generic single port ram with registered read
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// File: tb/sv/rpn_stack_evaluator_test.sv
// testbench for the postfix evaluator: directed and random token streams checked against a stack predictor
module rpn_stack_evaluator_test
    import rpn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct {
        logic signed [31:0] top;
        logic [6:0]         depth;
        logic [1:0]         stat;
    } eval_result_t;

    class eval_scoreboard;
        logic signed [31:0] stack_mem[DEPTH];
        int                 sp;
        eval_result_t       pending[$];
        int                 errors;

        function new();
            sp = 0;
            errors = 0;
        endfunction

        function logic signed [31:0] clamp(logic signed [63:0] v);
            if (v > 64'sh7fffffff) return SAT_MAX;
            if (v < -64'sh80000000) return SAT_MIN;
            return v[31:0];
        endfunction

        function void note_token(logic kind, logic signed [31:0] num, logic [2:0] op);
            eval_result_t r;
            logic signed [63:0] lhs, rhs, res;
            logic [1:0] st;
            st = ST_OK;
            if (kind == OP_KIND_NUM) begin
                if (sp >= DEPTH) begin
                    sp = 0;
                    st = ST_FULL;
                end
                else begin
                    stack_mem[sp] = num;
                    sp++;
                end
            end
            else if (sp < 2) begin
                sp = 0;
                st = ST_UNDER;
            end
            else begin
                rhs = stack_mem[sp-1];
                lhs = stack_mem[sp-2];
                sp -= 2;
                res = 0;
                case (op)
                    OP_ADD: res = clamp(lhs + rhs);
                    OP_SUB: res = clamp(lhs - rhs);
                    OP_MUL: res = clamp((lhs * rhs) / 65536);
                    OP_DIV:
                    begin
                        if (rhs == 0) begin
                            sp = 0;
                            st = ST_DIVZ;
                        end
                        else res = clamp((lhs * 65536) / rhs);
                    end
                    default: res = 0;
                endcase
                if (st == ST_OK) begin
                    stack_mem[sp] = res[31:0];
                    sp++;
                end
            end
            r.top = (sp > 0) ? stack_mem[sp-1] : 32'sd0;
            r.depth = sp[6:0];
            r.stat = st;
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] top, logic [6:0] depth, logic [1:0] stat);
            eval_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result top=%h depth=%0d status=%0d",
                    top, depth, stat);
                return;
            end
            e = pending.pop_front();
            if (top !== e.top || depth !== e.depth || stat !== e.stat) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected top=%h depth=%0d status=%0d, ",
                        "got top=%h depth=%0d status=%0d"},
                        e.top, e.depth, e.stat, top, depth, stat);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               req_type;
    logic signed [31:0] number_value;
    logic [2:0]         op_code;
    logic               done;
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [1:0]         status;

    eval_scoreboard sb;
    int burst_left;

    rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .number_value(number_value), .op_code(op_code),
        .done(done), .top_value(top_value), .stack_depth(stack_depth), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(top_value, stack_depth, status);
    end

    function automatic logic signed [31:0] rand_number();
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            4: return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(logic kind, logic signed [31:0] num, logic [2:0] op);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_type <= kind;
        number_value <= num;
        op_code <= op;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_token(kind, num, op);
        @(negedge clk);
        start <= 1'b0;
        number_value <= $urandom;
        op_code <= 3'($urandom);
        while (busy) @(negedge clk);
    endtask

    task automatic push_num(logic signed [31:0] v);
        send_token(OP_KIND_NUM, v, 3'($urandom));
    endtask

    task automatic apply_op(logic [2:0] op);
        send_token(~OP_KIND_NUM, $urandom, op);
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int n;
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = 1'b0;
        number_value = '0;
        op_code = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed tokens
        apply_op(OP_ADD);
        push_num(SAT_MAX); push_num(SAT_MAX); apply_op(OP_ADD);
        push_num(SAT_MIN); push_num(32'sh00010000); apply_op(OP_SUB);
        push_num(32'sh00028000); apply_op(OP_MUL);
        push_num(32'sh00030000); apply_op(OP_DIV);
        push_num(32'sh00000000); apply_op(OP_DIV);
        push_num(32'sh00050000); push_num(32'shfffd0000); apply_op(3'd4);
        push_num(SAT_MIN); push_num(32'sh00000001); apply_op(OP_DIV);
        push_num(32'sh00000007); apply_op(3'd7);
        apply_op(OP_SUB);

        // fill to full, then overflow
        for (int i = 0; i < DEPTH + 1; i++) push_num(rand_number());

        n = 0;
        while (n < 310) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    push_num(rand_number());
                    n++;
                end
            end
            else if (r < 94) begin
                apply_op(3'($urandom_range(0, 3)));
                n++;
            end
            else if (r < 97) begin
                apply_op(3'($urandom_range(4, 7)));
                n++;
            end
            else begin
                while (sb.sp < DEPTH) begin
                    push_num(rand_number());
                    n++;
                end
                push_num(rand_number());
                n++;
            end
        end

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
